/* rtl/i2cram_pkg.sv */
// shared types and constants of the i2c register access master
package i2cram_pkg;

    localparam logic [7:0] PHASE_TICKS_RESET = 8'd2;
    localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;
    localparam int         QUEUE_DEPTH       = 2;
    localparam int         CFG_DATA_W        = 8;
    localparam int         CFG_INDEX_W       = 1;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_TICKS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACK_TIMEOUT = 1'b1;

    // one tick as it travels from the front to the back
    typedef struct packed {
        logic       start_request;
        logic       operation;
        logic [6:0] device_address;
        logic [7:0] register_index;
        logic [7:0] write_value;
        logic       sda_in;
    } tick_t;

    // one result item
    typedef struct packed {
        logic [7:0] read_data;
        logic       ack_error;
        logic       done_res;
        logic       busy_res;
        logic       sda_level;
        logic       scl_level;
    } result_t;

endpackage

/* rtl/i2c_register_access_master_top.sv */
// top level of the i2c register access master: tick queue and bus sequencer
//
//  channel   dir  fields (lowest bit up)                          handshake
//  s_*       in   tdata: start_request, device_address,           tvalid/tready
//                 register_index, write_value, sda_in; tuser: operation
//  m_*       out  tdata: scl_level, sda_level, busy_res, done_res,  tvalid/tready
//                 ack_error, read_data
//  cfg_*     in   0 phase_ticks, 1 ack_timeout_ticks               cfg_we, no wait
//
// one tick item is taken every cycle while s_tready is high; its result appears in the
// cycle after it leaves the queue; items pass the tick queue, then the result register
// every item yields exactly one result item, in order
// reset clears all control state at once; no clearing pass is needed
// a stalled result side fills the queue, then s_tready drops until m_tready returns
module i2c_register_access_master_top #(
    parameter int QueueDepth = i2cram_pkg::QUEUE_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // start_request[0], device_address[7:1], register_index[15:8],
    // write_value[23:16], sda_in[24], zero fill [31:25]
    input  logic [31:0]                         s_tdata,
    // operation[0]
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // scl_level[0], sda_level[1], busy_res[2], done_res[3], ack_error[4],
    // read_data[12:5], zero fill [15:13]
    output logic [15:0]                         m_tdata,
    input  logic                                cfg_we,
    input  logic [i2cram_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [i2cram_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // queue between the front end and the sequencer
    logic                q_valid;
    logic                q_pop;
    i2cram_pkg::tick_t   q_item;
    i2cram_pkg::result_t res_item;

    i2cram_front #(
        .Depth (QueueDepth)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    // sequencer steps once per queued tick
    i2cram_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res_item  (res_item)
    );

    // pack the result, first field lowest
    assign m_tdata = {3'b000, res_item.read_data, res_item.ack_error, res_item.done_res,
                      res_item.busy_res, res_item.sda_level, res_item.scl_level};

endmodule

/* rtl/i2cram_front.sv */
// front end: unpacks incoming ticks and queues them for the engine
module i2cram_front #(
    parameter int Depth = i2cram_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [31:0]         s_tdata,
    input  logic                s_tuser,
    output logic                q_valid,
    input  logic                q_pop,
    output i2cram_pkg::tick_t   q_item
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    i2cram_pkg::tick_t   slot_reg [Depth];
    logic [PtrW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]     count_reg, count_next;
    i2cram_pkg::tick_t   unpacked;
    logic                push;

    always_comb
    begin
        unpacked.start_request  = s_tdata[0];
        unpacked.device_address = s_tdata[7:1];
        unpacked.register_index = s_tdata[15:8];
        unpacked.write_value    = s_tdata[23:16];
        unpacked.sda_in         = s_tdata[24];
        unpacked.operation      = s_tuser;
    end

    assign s_tready = (count_reg < CntW'(Depth));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign q_item   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (q_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= unpacked;
        end
    end

endmodule

/* rtl/i2cram_engine.sv */
// back end: bus phase sequencer, configuration registers and result register
module i2cram_engine (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  q_valid,
    output logic                                  q_pop,
    input  i2cram_pkg::tick_t                     q_item,
    input  logic                                  cfg_we,
    input  logic [i2cram_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [i2cram_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                  res_valid,
    input  logic                                  res_ready,
    output i2cram_pkg::result_t                   res_item
);

    typedef enum logic [18:0] {
        PH_IDLE     = 19'h00001,
        PH_STSET1   = 19'h00002,
        PH_STSET2   = 19'h00004,
        PH_STHOLD1  = 19'h00008,
        PH_STHOLD2  = 19'h00010,
        PH_TXLOW    = 19'h00020,
        PH_TXHIGH   = 19'h00040,
        PH_ACKLOW   = 19'h00080,
        PH_ACKHIGH  = 19'h00100,
        PH_RSPREP   = 19'h00200,
        PH_RXLOW    = 19'h00400,
        PH_RXHIGH   = 19'h00800,
        PH_NACKLOW  = 19'h01000,
        PH_NACKHIGH = 19'h02000,
        PH_SPLOW1   = 19'h04000,
        PH_SPLOW2   = 19'h08000,
        PH_SPRISE   = 19'h10000,
        PH_SPEND1   = 19'h20000,
        PH_SPEND2   = 19'h40000
    } phase_t;

    typedef enum logic [2:0] {
        STG_ADDR_W = 3'd0,
        STG_REG    = 3'd1,
        STG_DATA   = 3'd2,
        STG_ADDR_R = 3'd3,
        STG_READ   = 3'd4
    } stage_t;

    typedef struct packed {
        logic       operation;
        logic [6:0] device_address;
        logic [7:0] register_index;
        logic [7:0] write_value;
    } request_t;

    logic [7:0]          phase_ticks_reg, ack_timeout_reg;
    phase_t              phase_reg, phase_next;
    stage_t              stage_reg, stage_next;
    logic [7:0]          tick_reg, tick_next;
    logic [3:0]          bit_reg, bit_next;
    logic [7:0]          shift_reg, shift_next;
    logic [7:0]          ack_wait_reg, ack_wait_next;
    request_t            req_reg, req_next;
    logic [7:0]          rx_byte_reg, rx_byte_next;
    logic                error_reg, error_next;
    i2cram_pkg::result_t result_reg, result_next;
    logic                result_valid_reg;

    logic [7:0]          p_eff, t_eff;
    logic [8:0]          tick_inc;
    logic                wrap;
    logic                scl, sda, busy, done;

    // byte sent for each step of the transaction
    function automatic logic [7:0] stage_byte(input stage_t stg, input request_t rq);
        logic [7:0] b;
        unique case (stg)
            STG_ADDR_W: b = {rq.device_address, 1'b0};
            STG_REG:    b = rq.register_index;
            STG_DATA:   b = rq.write_value;
            default:    b = {rq.device_address, 1'b1};
        endcase
        return b;
    endfunction

    assign q_pop    = q_valid && (!result_valid_reg || res_ready);
    assign p_eff    = (phase_ticks_reg == 8'd0) ? 8'd1 : phase_ticks_reg;
    assign t_eff    = (ack_timeout_reg == 8'd0) ? 8'd1 : ack_timeout_reg;
    assign tick_inc = {1'b0, tick_reg} + 9'd1;
    assign wrap     = (tick_inc >= {1'b0, p_eff});

    // line drive for the current phase
    always_comb
    begin
        scl = 1'b1;
        sda = 1'b1;
        unique case (phase_reg)
            PH_STHOLD1, PH_STHOLD2, PH_SPRISE: sda = 1'b0;
            PH_TXLOW:
            begin
                scl = 1'b0;
                sda = shift_reg[7];
            end
            PH_TXHIGH: sda = shift_reg[7];
            PH_ACKLOW, PH_RSPREP, PH_RXLOW, PH_NACKLOW: scl = 1'b0;
            PH_SPLOW1, PH_SPLOW2:
            begin
                scl = 1'b0;
                sda = 1'b0;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        phase_next    = phase_reg;
        stage_next    = stage_reg;
        tick_next     = tick_reg;
        bit_next      = bit_reg;
        shift_next    = shift_reg;
        ack_wait_next = ack_wait_reg;
        req_next      = req_reg;
        rx_byte_next  = rx_byte_reg;
        error_next    = error_reg;
        busy          = 1'b1;
        done          = 1'b0;

        unique case (phase_reg)
            PH_ACKHIGH:
            begin
                if (tick_reg < p_eff)
                begin
                    tick_next = tick_inc[7:0];
                end
                if (!q_item.sda_in)
                begin
                    if (tick_next >= p_eff)
                    begin
                        tick_next = 8'd0;
                        unique case (stage_reg)
                            STG_ADDR_W:
                            begin
                                stage_next = STG_REG;
                                shift_next = stage_byte(STG_REG, req_reg);
                                bit_next   = 4'd0;
                                phase_next = PH_TXLOW;
                            end
                            STG_REG:
                            begin
                                if (req_reg.operation)
                                begin
                                    stage_next = STG_ADDR_R;
                                    phase_next = PH_RSPREP;
                                end
                                else
                                begin
                                    stage_next = STG_DATA;
                                    shift_next = stage_byte(STG_DATA, req_reg);
                                    bit_next   = 4'd0;
                                    phase_next = PH_TXLOW;
                                end
                            end
                            STG_ADDR_R:
                            begin
                                stage_next = STG_READ;
                                bit_next   = 4'd0;
                                shift_next = 8'd0;
                                phase_next = PH_RXLOW;
                            end
                            default: phase_next = PH_SPLOW1;
                        endcase
                    end
                end
                else
                begin
                    ack_wait_next = ack_wait_reg + 8'd1;
                    if (ack_wait_next >= t_eff)
                    begin
                        error_next = 1'b1;
                        tick_next  = 8'd0;
                        phase_next = PH_SPLOW1;
                    end
                end
            end
            PH_STSET1, PH_STSET2, PH_STHOLD1, PH_STHOLD2, PH_TXLOW, PH_TXHIGH,
            PH_ACKLOW, PH_RSPREP, PH_RXLOW, PH_RXHIGH, PH_NACKLOW, PH_NACKHIGH,
            PH_SPLOW1, PH_SPLOW2, PH_SPRISE, PH_SPEND1, PH_SPEND2:
            begin
                tick_next = wrap ? 8'd0 : tick_inc[7:0];
                if (wrap)
                begin
                    unique case (phase_reg)
                        PH_STSET1:  phase_next = PH_STSET2;
                        PH_STSET2:  phase_next = PH_STHOLD1;
                        PH_STHOLD1: phase_next = PH_STHOLD2;
                        PH_STHOLD2:
                        begin
                            shift_next = stage_byte(stage_reg, req_reg);
                            bit_next   = 4'd0;
                            phase_next = PH_TXLOW;
                        end
                        PH_TXLOW:   phase_next = PH_TXHIGH;
                        PH_TXHIGH:
                        begin
                            shift_next = {shift_reg[6:0], 1'b0};
                            if (bit_reg + 4'd1 >= 4'd8)
                            begin
                                bit_next   = 4'd0;
                                phase_next = PH_ACKLOW;
                            end
                            else
                            begin
                                bit_next   = bit_reg + 4'd1;
                                phase_next = PH_TXLOW;
                            end
                        end
                        PH_ACKLOW:
                        begin
                            ack_wait_next = 8'd0;
                            phase_next    = PH_ACKHIGH;
                        end
                        PH_RSPREP:  phase_next = PH_STSET1;
                        PH_RXLOW:   phase_next = PH_RXHIGH;
                        PH_RXHIGH:
                        begin
                            shift_next = {shift_reg[6:0], q_item.sda_in};
                            if (bit_reg + 4'd1 >= 4'd8)
                            begin
                                bit_next     = 4'd0;
                                rx_byte_next = {shift_reg[6:0], q_item.sda_in};
                                phase_next   = PH_NACKLOW;
                            end
                            else
                            begin
                                bit_next   = bit_reg + 4'd1;
                                phase_next = PH_RXLOW;
                            end
                        end
                        PH_NACKLOW:  phase_next = PH_NACKHIGH;
                        PH_NACKHIGH: phase_next = PH_SPLOW1;
                        PH_SPLOW1:   phase_next = PH_SPLOW2;
                        PH_SPLOW2:   phase_next = PH_SPRISE;
                        PH_SPRISE:   phase_next = PH_SPEND1;
                        PH_SPEND1:   phase_next = PH_SPEND2;
                        default:
                        begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                    endcase
                end
            end
            default:
            begin
                // idle: only here is a request looked at
                phase_next = PH_IDLE;
                tick_next  = 8'd0;
                busy       = 1'b0;
                if (q_item.start_request)
                begin
                    req_next.operation      = q_item.operation;
                    req_next.device_address = q_item.device_address;
                    req_next.register_index = q_item.register_index;
                    req_next.write_value    = q_item.write_value;
                    error_next    = 1'b0;
                    stage_next    = STG_ADDR_W;
                    bit_next      = 4'd0;
                    ack_wait_next = 8'd0;
                    busy          = 1'b1;
                    phase_next    = PH_STSET1;
                end
            end
        endcase

        result_next.scl_level = scl;
        result_next.sda_level = sda;
        result_next.busy_res  = busy;
        result_next.done_res  = done;
        result_next.ack_error = done && error_reg;
        result_next.read_data = rx_byte_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg  <= i2cram_pkg::PHASE_TICKS_RESET;
            ack_timeout_reg  <= i2cram_pkg::ACK_TIMEOUT_RESET;
            phase_reg        <= PH_IDLE;
            stage_reg        <= STG_ADDR_W;
            tick_reg         <= 8'd0;
            bit_reg          <= 4'd0;
            shift_reg        <= 8'd0;
            ack_wait_reg     <= 8'd0;
            req_reg          <= '0;
            rx_byte_reg      <= 8'd0;
            error_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == i2cram_pkg::CFG_PHASE_TICKS))
            begin
                phase_ticks_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == i2cram_pkg::CFG_ACK_TIMEOUT))
            begin
                ack_timeout_reg <= cfg_data;
            end
            if (q_pop)
            begin
                phase_reg    <= phase_next;
                stage_reg    <= stage_next;
                tick_reg     <= tick_next;
                bit_reg      <= bit_next;
                shift_reg    <= shift_next;
                ack_wait_reg <= ack_wait_next;
                req_reg      <= req_next;
                rx_byte_reg  <= rx_byte_next;
                error_reg    <= error_next;
            end
            if (q_pop)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            result_reg <= result_next;
        end
    end

    assign res_valid = result_valid_reg;
    assign res_item  = result_reg;

    a_error_only_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.ack_error) |-> result_reg.done_res)
        else $error("ack error reported without done");

    a_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.done_res) |-> result_reg.busy_res)
        else $error("done reported outside a transaction");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && (phase_reg == PH_IDLE) && !q_item.start_request)
        |=> (phase_reg == PH_IDLE) && !result_reg.busy_res)
        else $error("sequencer left idle without a request");

endmodule

/* tb/i2c_register_access_master_top_tb.sv */
// testbench of the i2c register access master: tick stimulus, bus predictor and result checking

// bus sequencer phases of the bus model, in sequence order
typedef enum logic [4:0] {
    BUS_IDLE, ST_SET1, ST_SET2, ST_HOLD1, ST_HOLD2, TX_LOW, TX_HIGH, ACK_LOW, ACK_HIGH,
    RS_PREP, RX_LOW, RX_HIGH, NACK_LOW, NACK_HIGH, SP_LOW1, SP_LOW2, SP_RISE, SP_END1, SP_END2
} bus_phase_e;

// which byte of the transaction is on the wire
typedef enum logic [2:0] {
    STAGE_ADDR_W, STAGE_REG, STAGE_DATA, STAGE_ADDR_R, STAGE_READ
} byte_stage_e;

// how the modeled slave answers in acknowledge slots
typedef enum logic [1:0] {
    SLAVE_ACKS, SLAVE_FLAKY, SLAVE_ABSENT
} slave_e;

class i2c_tick_scoreboard;
    logic [7:0]               half_ticks;
    logic [7:0]               ack_limit;
    bus_phase_e               phase;
    logic [7:0]               tick_cnt;
    logic [3:0]               bit_cnt;
    logic [7:0]               shift;
    logic [7:0]               ack_wait;
    logic [23:0]              req;
    logic [7:0]               rx_byte;
    logic                     err;
    byte_stage_e              stage;
    i2cram_pkg::result_t      expected_results[$];
    int                       errors;
    int                       result_count;

    function new();
        half_ticks   = i2cram_pkg::PHASE_TICKS_RESET;
        ack_limit    = i2cram_pkg::ACK_TIMEOUT_RESET;
        phase        = BUS_IDLE;
        tick_cnt     = '0;
        bit_cnt      = '0;
        shift        = '0;
        ack_wait     = '0;
        req          = '0;
        rx_byte      = '0;
        err          = 1'b0;
        stage        = STAGE_ADDR_W;
        errors       = 0;
        result_count = 0;
    endfunction

    function void set_config(logic [i2cram_pkg::CFG_INDEX_W-1:0] idx, logic [7:0] value);
        if (idx == i2cram_pkg::CFG_PHASE_TICKS)
            half_ticks = value;
        else
            ack_limit = value;
    endfunction

    function bit bus_idle();
        return phase == BUS_IDLE;
    endfunction

    function bit waiting_ack();
        return phase == ACK_HIGH;
    endfunction

    function int pending_count();
        return expected_results.size();
    endfunction

    function void go(bus_phase_e nxt);
        phase    = nxt;
        tick_cnt = '0;
    endfunction

    function void load_byte();
        case (stage)
            STAGE_ADDR_W: shift = {req[22:16], 1'b0};
            STAGE_REG:    shift = req[15:8];
            STAGE_DATA:   shift = req[7:0];
            default:      shift = {req[22:16], 1'b1};
        endcase
        bit_cnt = '0;
    endfunction

    // advance the bus model by one tick and queue the result it must produce
    function void note_tick(i2cram_pkg::tick_t tk);
        i2cram_pkg::result_t r;
        int                  p;
        int                  t;
        bus_phase_e          ph;
        bit                  timed;
        p           = (half_ticks == 0) ? 1 : int'(half_ticks);
        t           = (ack_limit == 0) ? 1 : int'(ack_limit);
        ph          = phase;
        r           = '0;
        r.scl_level = 1'b1;
        r.sda_level = 1'b1;
        r.busy_res  = 1'b1;
        timed       = 1'b1;

        case (ph)
            ST_HOLD1, ST_HOLD2, SP_RISE: r.sda_level = 1'b0;
            TX_LOW:
            begin
                r.scl_level = 1'b0;
                r.sda_level = shift[7];
            end
            TX_HIGH: r.sda_level = shift[7];
            ACK_LOW, RS_PREP, RX_LOW, NACK_LOW: r.scl_level = 1'b0;
            SP_LOW1, SP_LOW2:
            begin
                r.scl_level = 1'b0;
                r.sda_level = 1'b0;
            end
            default: ;
        endcase

        if (ph == ACK_HIGH)
        begin
            timed = 1'b0;
            if (tick_cnt < p)
                tick_cnt++;
            if (!tk.sda_in)
            begin
                // a low level counts only after a full high phase
                if (tick_cnt >= p)
                begin
                    case (stage)
                        STAGE_ADDR_W:
                        begin
                            stage = STAGE_REG;
                            load_byte();
                            go(TX_LOW);
                        end
                        STAGE_REG:
                            if (req[23])
                            begin
                                stage = STAGE_ADDR_R;
                                go(RS_PREP);
                            end
                            else
                            begin
                                stage = STAGE_DATA;
                                load_byte();
                                go(TX_LOW);
                            end
                        STAGE_ADDR_R:
                        begin
                            stage   = STAGE_READ;
                            bit_cnt = '0;
                            shift   = '0;
                            go(RX_LOW);
                        end
                        default: go(SP_LOW1);
                    endcase
                end
            end
            else
            begin
                ack_wait++;
                if (ack_wait >= t)
                begin
                    err = 1'b1;
                    go(SP_LOW1);
                end
            end
        end
        else if (ph == BUS_IDLE)
        begin
            timed      = 1'b0;
            tick_cnt   = '0;
            r.busy_res = 1'b0;
            if (tk.start_request)
            begin
                req        = {tk.operation, tk.device_address, tk.register_index, tk.write_value};
                err        = 1'b0;
                stage      = STAGE_ADDR_W;
                bit_cnt    = '0;
                ack_wait   = '0;
                r.busy_res = 1'b1;
                go(ST_SET1);
            end
        end

        if (timed)
        begin
            tick_cnt++;
            if (tick_cnt >= p)
            begin
                tick_cnt = '0;
                case (ph)
                    ST_SET1:  go(ST_SET2);
                    ST_SET2:  go(ST_HOLD1);
                    ST_HOLD1: go(ST_HOLD2);
                    ST_HOLD2:
                    begin
                        load_byte();
                        go(TX_LOW);
                    end
                    TX_LOW: go(TX_HIGH);
                    TX_HIGH:
                    begin
                        shift = shift << 1;
                        bit_cnt++;
                        if (bit_cnt >= 8)
                        begin
                            bit_cnt = '0;
                            go(ACK_LOW);
                        end
                        else
                            go(TX_LOW);
                    end
                    ACK_LOW:
                    begin
                        ack_wait = '0;
                        go(ACK_HIGH);
                    end
                    RS_PREP: go(ST_SET1);
                    RX_LOW:  go(RX_HIGH);
                    RX_HIGH:
                    begin
                        shift = {shift[6:0], tk.sda_in};
                        bit_cnt++;
                        if (bit_cnt >= 8)
                        begin
                            bit_cnt = '0;
                            rx_byte = shift;
                            go(NACK_LOW);
                        end
                        else
                            go(RX_LOW);
                    end
                    NACK_LOW:  go(NACK_HIGH);
                    NACK_HIGH: go(SP_LOW1);
                    SP_LOW1:   go(SP_LOW2);
                    SP_LOW2:   go(SP_RISE);
                    SP_RISE:   go(SP_END1);
                    SP_END1:   go(SP_END2);
                    default:
                    begin
                        // last tick of the final stop
                        go(BUS_IDLE);
                        r.done_res = 1'b1;
                    end
                endcase
            end
        end

        r.ack_error = r.done_res & err;
        r.read_data = rx_byte;
        expected_results.push_back(r);
    endfunction

    task report(string msg);
        $display("mismatch at result %0d: %s", result_count, msg);
        errors++;
    endtask

    task check_result(i2cram_pkg::result_t got);
        i2cram_pkg::result_t want;
        if (expected_results.size() == 0)
        begin
            report("result with no tick waiting");
            result_count++;
            return;
        end
        want = expected_results.pop_front();
        if (got.scl_level !== want.scl_level)
            report($sformatf("scl_level expected %0b got %0b", want.scl_level, got.scl_level));
        if (got.sda_level !== want.sda_level)
            report($sformatf("sda_level expected %0b got %0b", want.sda_level, got.sda_level));
        if (got.busy_res !== want.busy_res)
            report($sformatf("busy_res expected %0b got %0b", want.busy_res, got.busy_res));
        if (got.done_res !== want.done_res)
            report($sformatf("done_res expected %0b got %0b", want.done_res, got.done_res));
        if (got.ack_error !== want.ack_error)
            report($sformatf("ack_error expected %0b got %0b", want.ack_error, got.ack_error));
        if (got.read_data !== want.read_data)
            report($sformatf("read_data expected %02h got %02h", want.read_data, got.read_data));
        result_count++;
    endtask
endclass

module i2c_register_access_master_top_tb;

    logic                                clk;
    logic                                rst_n;
    logic                                s_tvalid;
    logic                                s_tready;
    logic [31:0]                         s_tdata;
    logic                                s_tuser;
    logic                                m_tvalid;
    logic                                m_tready;
    logic [15:0]                         m_tdata;
    logic                                cfg_we;
    logic [i2cram_pkg::CFG_INDEX_W-1:0]  cfg_index;
    logic [i2cram_pkg::CFG_DATA_W-1:0]   cfg_data;

    i2c_tick_scoreboard sb;
    slave_e             slave_mode;
    bit                 quiet;       // no idling on either side while set
    int                 sent_ticks;
    int                 random_base;
    int                 txn_count;

    i2c_register_access_master_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 12 unit clock period
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // result side stalls about a third of the time unless quiet
    always @(negedge clk)
        m_tready <= quiet || ($urandom_range(99) >= 32);

    // sample both handshakes at the rising edge; the tick is noted before any result
    // is checked, though a result never comes in the cycle its tick was taken
    always @(posedge clk)
    begin
        i2cram_pkg::tick_t   tk;
        i2cram_pkg::result_t rs;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                tk.start_request  = s_tdata[0];
                tk.device_address = s_tdata[7:1];
                tk.register_index = s_tdata[15:8];
                tk.write_value    = s_tdata[23:16];
                tk.sda_in         = s_tdata[24];
                tk.operation      = s_tuser;
                sb.note_tick(tk);
            end
            if (m_tvalid && m_tready)
            begin
                rs.scl_level = m_tdata[0];
                rs.sda_level = m_tdata[1];
                rs.busy_res  = m_tdata[2];
                rs.done_res  = m_tdata[3];
                rs.ack_error = m_tdata[4];
                rs.read_data = m_tdata[12:5];
                sb.check_result(rs);
            end
        end
    end

    // entered and left at a falling edge; sda_in is picked from the bus model as it
    // stands once every earlier tick has been noted
    task automatic send_tick(input logic start, input logic op, input logic [6:0] addr,
                             input logic [7:0] rg, input logic [7:0] val);
        logic sda;
        while (!quiet && $urandom_range(99) < 32)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        if (sb.waiting_ack())
        begin
            case (slave_mode)
                SLAVE_ACKS:  sda = 1'b0;
                SLAVE_FLAKY: sda = 1'($urandom_range(1));
                default:     sda = 1'b1;
            endcase
        end
        else
            sda = 1'($urandom_range(1));   // read bits and line noise
        s_tdata  <= {7'b0, sda, val, rg, addr, start};
        s_tuser  <= op;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_ticks++;
        @(negedge clk);
    endtask

    // one request from idle, then ticks until the bus is idle again; the ticks in
    // between carry random requests that a busy block must ignore
    task automatic run_transaction(input logic op, input logic [6:0] addr,
                                   input logic [7:0] rg, input logic [7:0] val,
                                   input slave_e mode);
        slave_mode = mode;
        send_tick(1'b1, op, addr, rg, val);
        while (!sb.bus_idle())
            send_tick(1'($urandom_range(1)), 1'($urandom_range(1)), 7'($urandom),
                      8'($urandom), 8'($urandom));
    endtask

    // stop sending and wait until every result is in, plus the block's latency
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_count() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_cfg(input logic [i2cram_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        sb.set_config(idx, value);
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // ends a run that hangs
    initial
    begin
        #(12 * 1000000);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        logic [7:0] p_pick;
        logic [7:0] t_pick;
        int         roll;
        sb         = new();
        slave_mode = SLAVE_ACKS;
        quiet      = 1'b0;
        sent_ticks = 0;
        txn_count  = 0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        m_tready   = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings: field extremes on a write, early acknowledge comes for
        // free since the slave pulls sda low as soon as scl rises
        run_transaction(1'b0, 7'h7f, 8'hff, 8'hff, SLAVE_ACKS);
        drain();

        // zero in both registers behaves as one; a missing acknowledge stops with
        // error and an aborted read keeps the old byte
        write_cfg(i2cram_pkg::CFG_PHASE_TICKS, 8'd0);
        write_cfg(i2cram_pkg::CFG_ACK_TIMEOUT, 8'd0);
        run_transaction(1'b1, 7'h00, 8'hff, 8'ha5, SLAVE_ACKS);
        run_transaction(1'b0, 7'h2a, 8'h55, 8'haa, SLAVE_ABSENT);
        run_transaction(1'b1, 7'h55, 8'haa, 8'h55, SLAVE_ABSENT);
        drain();

        // random part: mostly well-formed transactions with random content, with
        // some noise ticks, flaky and absent slaves; settings change every two
        random_base = sent_ticks;
        while (sent_ticks - random_base < 160)
        begin
            quiet = (sent_ticks - random_base >= 50) && (sent_ticks - random_base < 120);
            if (txn_count % 2 == 0)
            begin
                drain();
                roll = $urandom_range(9);
                if (roll < 6)
                    p_pick = 8'd1;
                else if (roll < 8)
                    p_pick = 8'($urandom_range(3, 2));
                else if (roll == 8)
                    p_pick = 8'd0;
                else
                    p_pick = 8'd3;
                roll = $urandom_range(9);
                if (roll < 6)
                    t_pick = 8'($urandom_range(12, 1));
                else if (roll < 8)
                    t_pick = 8'($urandom_range(40, 13));
                else if (roll == 8)
                    t_pick = 8'd0;
                else
                    t_pick = 8'd255;
                write_cfg(i2cram_pkg::CFG_PHASE_TICKS, p_pick);
                write_cfg(i2cram_pkg::CFG_ACK_TIMEOUT, t_pick);
            end
            repeat ($urandom_range(3))
                send_tick(1'b0, 1'($urandom_range(1)), 7'($urandom), 8'($urandom),
                          8'($urandom));
            roll = $urandom_range(99);
            run_transaction(1'($urandom_range(1)), 7'($urandom), 8'($urandom), 8'($urandom),
                            (roll < 70) ? SLAVE_ACKS : (roll < 85) ? SLAVE_FLAKY : SLAVE_ABSENT);
            txn_count++;
        end
        quiet = 1'b0;

        drain();
        repeat (16) @(negedge clk);
        if (sb.errors == 0 && sb.pending_count() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
